// File: design/ier_pkg.sv
// ----------------------------------------------------------------------------
// ier_pkg
// Shared constants and types for the ICMP echo responder: header layout,
// counter widths and the command and status bundles between control and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ier_pkg;

    localparam int MAX_PACKET_BYTES = 1024;
    localparam int HDR_BYTES        = 28;
    localparam int IP_HDR_BYTES     = 20;
    localparam int COUNT_W          = 11;
    localparam int HDR_AW           = $clog2(HDR_BYTES);

    localparam logic [7:0] ICMP_TYPE_REQUEST = 8'd8;
    localparam logic [7:0] ICMP_TYPE_REPLY   = 8'd0;
    localparam logic [15:0] ECHO_CSUM_ADJ    = 16'h0800;

    localparam logic [COUNT_W-1:0] MAX_COUNT    = COUNT_W'(MAX_PACKET_BYTES);
    localparam logic [COUNT_W-1:0] HDR_LAST_POS = COUNT_W'(HDR_BYTES - 1);

    // byte positions inside the held header
    localparam logic [HDR_AW-1:0] POS_IP_CSUM_HI   = HDR_AW'(10);
    localparam logic [HDR_AW-1:0] POS_IP_CSUM_LO   = HDR_AW'(11);
    localparam logic [HDR_AW-1:0] POS_SRC_FIRST    = HDR_AW'(12);
    localparam logic [HDR_AW-1:0] POS_DST_FIRST    = HDR_AW'(16);
    localparam logic [HDR_AW-1:0] POS_IP_END       = HDR_AW'(IP_HDR_BYTES);
    localparam logic [HDR_AW-1:0] POS_ICMP_TYPE    = HDR_AW'(20);
    localparam logic [HDR_AW-1:0] POS_ICMP_CSUM_HI = HDR_AW'(22);
    localparam logic [HDR_AW-1:0] POS_ICMP_CSUM_LO = HDR_AW'(23);
    localparam logic [HDR_AW-1:0] POS_HDR_LAST     = HDR_AW'(HDR_BYTES - 1);
    localparam logic [HDR_AW-1:0] ADDR_SWAP_OFS    = HDR_AW'(4);

    typedef struct packed {
        logic              hdr_wr;     // store header byte at hdr_pos
        logic [HDR_AW-1:0] hdr_pos;
        logic              pass;       // forward payload byte to output
        logic              rd_en;      // read header store for emit_idx
        logic              hdr_load;   // load rewritten header byte to output
        logic [HDR_AW-1:0] emit_idx;
        logic              emit_last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_echo;
    } status_t;

endpackage

`default_nettype wire

// File: design/ier_datapath.sv
// ----------------------------------------------------------------------------
// ier_datapath
// Header store, running IP header sum, ICMP checksum capture, header
// rewrite and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ier_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [7:0]     s_tdata,
    input  wire logic           s_tlast,
    input  wire ier_pkg::cmd_t  cmd,
    output ier_pkg::status_t    status,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);

    logic [7:0]  hdr_mem [0:ier_pkg::HDR_BYTES-1];
    logic [7:0]  rd_data_reg;
    logic [ier_pkg::HDR_AW-1:0] rd_addr;

    logic [19:0] sum_reg, sum_next;
    logic [19:0] addend;
    logic [7:0]  type_reg, type_next;
    logic [15:0] icmp_reg, icmp_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;

    logic [16:0] ip_fold1;
    logic [15:0] ip_fold2;
    logic [15:0] ip_csum;
    logic [16:0] icmp_add;
    logic [15:0] icmp_csum;
    logic [7:0]  hdr_byte;

    // source and destination addresses trade places on the way out
    always_comb
    begin
        rd_addr = cmd.emit_idx;
        if (cmd.emit_idx >= ier_pkg::POS_SRC_FIRST && cmd.emit_idx < ier_pkg::POS_DST_FIRST)
        begin
            rd_addr = cmd.emit_idx + ier_pkg::ADDR_SWAP_OFS;
        end
        else if (cmd.emit_idx >= ier_pkg::POS_DST_FIRST
                 && cmd.emit_idx < ier_pkg::POS_IP_END)
        begin
            rd_addr = cmd.emit_idx - ier_pkg::ADDR_SWAP_OFS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hdr_wr)
        begin
            hdr_mem[cmd.hdr_pos] <= s_tdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= hdr_mem[rd_addr];
        end
    end

    // big-endian 16-bit words, checksum word left out
    always_comb
    begin
        addend    = cmd.hdr_pos[0] ? {12'd0, s_tdata} : {4'd0, s_tdata, 8'd0};
        sum_next  = sum_reg;
        type_next = type_reg;
        icmp_next = icmp_reg;
        if (cmd.hdr_wr)
        begin
            if (cmd.hdr_pos == '0)
            begin
                sum_next = addend;
            end
            else if (cmd.hdr_pos < ier_pkg::POS_IP_END
                     && cmd.hdr_pos != ier_pkg::POS_IP_CSUM_HI
                     && cmd.hdr_pos != ier_pkg::POS_IP_CSUM_LO)
            begin
                sum_next = sum_reg + addend;
            end
            if (cmd.hdr_pos == ier_pkg::POS_ICMP_TYPE)
            begin
                type_next = s_tdata;
            end
            if (cmd.hdr_pos == ier_pkg::POS_ICMP_CSUM_HI)
            begin
                icmp_next = {s_tdata, icmp_reg[7:0]};
            end
            if (cmd.hdr_pos == ier_pkg::POS_ICMP_CSUM_LO)
            begin
                icmp_next = {icmp_reg[15:8], s_tdata};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        type_reg <= type_next;
        icmp_reg <= icmp_next;
    end

    // end-around carry folds
    assign ip_fold1  = {1'b0, sum_reg[15:0]} + {13'd0, sum_reg[19:16]};
    assign ip_fold2  = ip_fold1[15:0] + {15'd0, ip_fold1[16]};
    assign ip_csum   = ~ip_fold2;
    assign icmp_add  = {1'b0, icmp_reg} + {1'b0, ier_pkg::ECHO_CSUM_ADJ};
    assign icmp_csum = icmp_add[15:0] + {15'd0, icmp_add[16]};

    always_comb
    begin
        if (cmd.emit_idx == ier_pkg::POS_IP_CSUM_HI)
        begin
            hdr_byte = ip_csum[15:8];
        end
        else if (cmd.emit_idx == ier_pkg::POS_IP_CSUM_LO)
        begin
            hdr_byte = ip_csum[7:0];
        end
        else if (cmd.emit_idx == ier_pkg::POS_ICMP_TYPE)
        begin
            hdr_byte = ier_pkg::ICMP_TYPE_REPLY;
        end
        else if (cmd.emit_idx == ier_pkg::POS_ICMP_CSUM_HI)
        begin
            hdr_byte = icmp_csum[15:8];
        end
        else if (cmd.emit_idx == ier_pkg::POS_ICMP_CSUM_LO)
        begin
            hdr_byte = icmp_csum[7:0];
        end
        else
        begin
            hdr_byte = rd_data_reg;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign status.is_echo  = (type_reg == ier_pkg::ICMP_TYPE_REQUEST);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (cmd.pass)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = s_tdata;
            out_last_next  = s_tlast;
        end
        else if (cmd.hdr_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = hdr_byte;
            out_last_next  = cmd.emit_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: design/ier_ctrl.sv
// ----------------------------------------------------------------------------
// ier_ctrl
// Packet position tracking, drop decision and the header emit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ier_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tlast,
    output logic                   s_tready,
    input  wire ier_pkg::status_t  status,
    output ier_pkg::cmd_t          cmd
);

    localparam logic [1:0] ST_RECV = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [ier_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        disc_reg, disc_next;
    logic [ier_pkg::HDR_AW-1:0]  idx_reg, idx_next;
    logic                        last_hdr_reg, last_hdr_next;
    logic                        accept;

    assign s_tready = (state_reg == ST_RECV) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        disc_next     = disc_reg;
        idx_next      = idx_reg;
        last_hdr_next = last_hdr_reg;

        cmd           = '0;
        cmd.hdr_pos   = count_reg[ier_pkg::HDR_AW-1:0];
        cmd.emit_idx  = idx_reg;
        cmd.emit_last = last_hdr_reg && (idx_reg == ier_pkg::POS_HDR_LAST);

        unique case (state_reg)
            ST_RECV:
            begin
                if (accept)
                begin
                    if (count_reg < ier_pkg::MAX_COUNT)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (count_reg < ier_pkg::HDR_LAST_POS)
                    begin
                        cmd.hdr_wr = 1'b1;
                    end
                    else if (count_reg == ier_pkg::HDR_LAST_POS)
                    begin
                        cmd.hdr_wr = 1'b1;
                        if (status.is_echo)
                        begin
                            state_next    = ST_READ;
                            idx_next      = '0;
                            last_hdr_next = s_tlast;
                        end
                        else
                        begin
                            disc_next = 1'b1;
                        end
                    end
                    else if (!disc_reg && count_reg < ier_pkg::MAX_COUNT)
                    begin
                        cmd.pass = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        count_next = '0;
                        disc_next  = 1'b0;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    cmd.hdr_load = 1'b1;
                    if (idx_reg == ier_pkg::POS_HDR_LAST)
                    begin
                        state_next = ST_RECV;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RECV;
            count_reg    <= '0;
            disc_reg     <= 1'b0;
            idx_reg      <= '0;
            last_hdr_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            disc_reg     <= disc_next;
            idx_reg      <= idx_next;
            last_hdr_reg <= last_hdr_next;
        end
    end

endmodule

`default_nettype wire

// File: design/icmp_echo_responder.sv
// ----------------------------------------------------------------------------
// icmp_echo_responder
// Byte-serial ICMP echo responder: rewrites echo requests into replies.
// ----------------------------------------------------------------------------
// Bytes of an IPv4 packet (20-byte header, no options) enter on the slave
// side, one per transfer, with tlast on the final byte. The first 28 bytes
// are held; bytes before the 28th produce no output. If the ICMP type is an
// echo request, the 28 rewritten header bytes (addresses swapped, IP header
// checksum recomputed, type set to reply, ICMP checksum adjusted) follow,
// then the payload passes through unchanged; any other packet, and any
// packet shorter than 28 bytes, is dropped. Bytes from position 1024 on are
// dropped. Header and payload bytes are taken at one per cycle while the
// output is drained. Each byte of the header burst passes the ST_READ and
// ST_SEND states: the registered read port of the header store, then the
// output register; the input is stalled during the burst.
`default_nettype none

module icmp_echo_responder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte[7:0]
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte[7:0]
    output logic            m_tlast
);

    ier_pkg::cmd_t    cmd;
    ier_pkg::status_t status;

    ier_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ier_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.pass && cmd.hdr_load))
        else $error("payload and header loaded together");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pass || cmd.hdr_load) |-> status.out_free)
        else $error("output register overwritten");

    a_burst_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> !(s_tvalid && s_tready))
        else $error("input accepted during header burst");
`endif

endmodule

`default_nettype wire

// File: verif/icmp_echo_responder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icmp_echo_responder_tb
// Self-checking bench for the byte-serial ICMP echo responder.
// ----------------------------------------------------------------------------
// Packets are queued as byte transfers and driven on the slave side with
// random gaps. Every accepted byte is run through a local predictor of the
// header rewrite and payload pass-through. The predicted reply bytes are
// compared in order with the master side while it stalls at random.
// Directed packets cover an exact 28-byte echo request, an echo request with
// all-one fill bytes and checksum carries, another ICMP type and a single-byte packet.
// Random packets follow.
// ----------------------------------------------------------------------------

module icmp_echo_responder_tb;

    import ier_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 100;
    localparam int IDLE_PCT     = 19;
    localparam int CALM_FROM    = 100;
    localparam int CALM_TO      = 200;
    localparam int TAIL_CYCLES  = 80;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold;      // wait for all replies to drain first
    } pkt_byte_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } reply_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tlast;

    pkt_byte_t  pend_q[$];
    reply_t     reply_q[$];
    reply_t     want;

    // predictor state
    logic [7:0]         held_hdr [HDR_BYTES];
    logic [COUNT_W-1:0] pkt_pos = '0;
    bit                 dropping = 1'b0;

    int unsigned cycles      = 0;
    int unsigned bytes_taken = 0;
    int unsigned total_bytes = 0;
    int unsigned fails       = 0;

    icmp_echo_responder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit idle_now();
        return !(cycles >= CALM_FROM && cycles < CALM_TO)
            && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    task automatic push_reply(input logic [7:0] data, input logic last);
        reply_t r;
        r.data = data;
        r.last = last;
        reply_q.push_back(r);
    endtask

    // works out the reply bytes caused by one accepted packet byte
    task automatic predict_reply(input logic [7:0] data, input logic last);
        logic [7:0]         hdr [HDR_BYTES];
        logic [COUNT_W-1:0] pos;
        logic [31:0]        acc;
        logic [16:0]        adj;
        int                 i;
        pos = pkt_pos;
        if (pkt_pos < MAX_COUNT)
            pkt_pos = pkt_pos + 1'b1;
        if (pos < HDR_LAST_POS)
        begin
            held_hdr[pos] = data;
        end
        else if (pos == HDR_LAST_POS)
        begin
            held_hdr[pos] = data;
            if (held_hdr[POS_ICMP_TYPE] != ICMP_TYPE_REQUEST)
            begin
                dropping = 1'b1;
            end
            else
            begin
                for (i = 0; i < HDR_BYTES; i++)
                    hdr[i] = held_hdr[i];
                for (i = 0; i < 4; i++)
                begin
                    hdr[POS_SRC_FIRST + i] = held_hdr[POS_DST_FIRST + i];
                    hdr[POS_DST_FIRST + i] = held_hdr[POS_SRC_FIRST + i];
                end
                // checksum word counts as zero while summing
                acc = 0;
                for (i = 0; i < IP_HDR_BYTES; i += 2)
                    if (i != POS_IP_CSUM_HI)
                        acc += {16'h0000, hdr[i], hdr[i + 1]};
                acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
                acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
                acc = ~acc;
                hdr[POS_IP_CSUM_HI] = acc[15:8];
                hdr[POS_IP_CSUM_LO] = acc[7:0];
                hdr[POS_ICMP_TYPE]  = ICMP_TYPE_REPLY;
                adj = {1'b0, hdr[POS_ICMP_CSUM_HI], hdr[POS_ICMP_CSUM_LO]}
                    + {1'b0, ECHO_CSUM_ADJ};
                adj = {1'b0, adj[15:0]} + {16'h0000, adj[16]};
                hdr[POS_ICMP_CSUM_HI] = adj[15:8];
                hdr[POS_ICMP_CSUM_LO] = adj[7:0];
                for (i = 0; i < HDR_BYTES; i++)
                    push_reply(hdr[i], (i == HDR_BYTES - 1) && last);
            end
        end
        else if (!dropping && pos < MAX_COUNT)
        begin
            push_reply(data, last);
        end
        if (last)
        begin
            pkt_pos  = '0;
            dropping = 1'b0;
        end
    endtask

    // fill < 0 gives random bytes; icmp_type < 0 leaves byte 20 as filled
    task automatic add_packet(input int len, input int icmp_type, input int fill,
                              input bit hold);
        pkt_byte_t it;
        int        i;
        for (i = 0; i < len; i++)
        begin
            it.data = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (i == POS_ICMP_TYPE && icmp_type >= 0)
                it.data = 8'(icmp_type);
            it.last = (i == len - 1);
            it.hold = hold && (i == 0);
            pend_q.push_back(it);
        end
        total_bytes += len;
    endtask

    // slave side driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_reply(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pend_q.size() > 0 && !(pend_q[0].hold && reply_q.size() > 0)
                    && !idle_now())
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pend_q[0].data;
                    s_tlast  <= pend_q[0].last;
                    void'(pend_q.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // master side monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("unexpected reply transfer: out_byte %02h out_last %0b",
                           m_tdata, m_tlast);
                    fails++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, m_tdata);
                        fails++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("out_last: expected %0b, got %0b", want.last, m_tlast);
                        fails++;
                    end
                end
            end
            m_tready <= !idle_now();
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int t;
        int r;
        // directed packets
        add_packet(HDR_BYTES, ICMP_TYPE_REQUEST, -1, 1'b0);   // exactly 28 bytes
        add_packet(30, ICMP_TYPE_REQUEST, 8'hFF, 1'b1);       // carries, after a full drain
        add_packet(29, ICMP_TYPE_REPLY, -1, 1'b0);            // not a request
        add_packet(1, -1, -1, 1'b0);                          // single-byte packet
        // random packets, mostly well-formed echo requests
        while (total_bytes < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                add_packet($urandom_range(HDR_BYTES, HDR_BYTES + 8), ICMP_TYPE_REQUEST,
                           -1, $urandom_range(0, 9) == 0);
            end
            else if (r < 85)
            begin
                t = $urandom_range(0, 255);
                if (t == ICMP_TYPE_REQUEST)
                    t = t + 1;
                add_packet($urandom_range(HDR_BYTES, HDR_BYTES + 4), t, -1, 1'b0);
            end
            else
            begin
                add_packet($urandom_range(1, HDR_BYTES - 1), -1, -1, 1'b0);
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < total_bytes || reply_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
